// ===== rtl/core/l3d_pkg.sv =====
package l3d_pkg;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  localparam logic [1:0] REG_LUT_SIDE = 2'd0;
  localparam logic [1:0] REG_BLEND    = 2'd1;

  localparam logic [8:0] BLEND_FULL = 9'd256;

  // Channel 0 is red, 1 is green, 2 is blue.
  typedef logic [2:0][15:0] entry_t;

  typedef struct packed {
    logic [2:0][7:0] px;
    logic [7:0]      alpha;
    logic            frame_end;
  } pix_side_t;

endpackage

// ===== rtl/core/lut3d_trilinear_pixel_map_core.sv =====
// Color grading of RGBA8 pixels through a 3D lookup table with trilinear interpolation.
// Table writes and pixels share one input stream and both are taken one per clock
// while the output is not stalled; a write gives no result and each pixel gives
// exactly one, presented on the outputs in order. The table is held in four copies,
// each with two read ports, so that the eight corners of a pixel are read in the
// same cycle; a write updates all copies and is seen by every pixel that follows it.
// The stages are: input register, scale, split, fraction and row offsets, base
// address, table read, three interpolation levels, blend and byte rounding into the
// output register. The user must write configuration only while the block holds no
// transaction; the block itself does not enforce this.
module lut3d_trilinear_pixel_map_core
  import l3d_pkg::*;
#(
  parameter int MAX_SIDE  = 33,
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        opcode,
  input  logic [15:0] entry_index,
  input  logic [15:0] entry_red,
  input  logic [15:0] entry_green,
  input  logic [15:0] entry_blue,
  input  logic [7:0]  pixel_red,
  input  logic [7:0]  pixel_green,
  input  logic [7:0]  pixel_blue,
  input  logic [7:0]  pixel_alpha,
  input  logic        frame_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  mapped_red,
  output logic [7:0]  mapped_green,
  output logic [7:0]  mapped_blue,
  output logic [7:0]  mapped_alpha,
  output logic        frame_end_out
);

  localparam int SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int PROD_W = 8 + SIDE_W;
  localparam int QW     = PROD_W + 10;
  localparam int SQ_W   = $clog2(MAX_SIDE * MAX_SIDE + 1);
  localparam int DEPTH  = MAX_SIDE * MAX_SIDE * MAX_SIDE;
  localparam int MEM_AW = $clog2(DEPTH);
  localparam int ADDR_W = $clog2(DEPTH + MAX_SIDE * MAX_SIDE + MAX_SIDE + 2);
  localparam int RC_W   = FRAC_BITS + 9;
  localparam int FP_W   = RC_W + 8;
  localparam logic [RC_W-1:0] FRAC_RECIP =
    RC_W'(((64'd1 << (FRAC_BITS + 16)) + 64'd254) / 64'd255);
  localparam int NS = 11;

  logic [5:0] lut_side;
  logic [8:0] blend_amount;

  always_ff @(posedge clk) begin
    if (rst) begin
      lut_side     <= '0;
      blend_amount <= BLEND_FULL;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_LUT_SIDE: lut_side <= cfg_data[5:0];
        REG_BLEND:    blend_amount <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [SIDE_W-1:0] side_n;
  logic [SIDE_W-1:0] side_nm1;
  logic [SQ_W-1:0]   side_nn;
  logic [8:0]        k_eff;
  logic [8:0]        k_inv;
  logic              bypass;

  assign side_n   = (32'(lut_side) > MAX_SIDE) ? SIDE_W'(MAX_SIDE) : SIDE_W'(lut_side);
  assign side_nm1 = side_n - SIDE_W'(1);
  assign side_nn  = SQ_W'(side_n) * SQ_W'(side_n);
  assign k_eff    = (blend_amount > BLEND_FULL) ? BLEND_FULL : blend_amount;
  assign k_inv    = BLEND_FULL - k_eff;
  assign bypass   = (lut_side == '0);

  logic [NS:1]   v;
  logic [NS+1:1] en;

  assign en[NS+1] = out_ready;
  for (genvar s = 1; s <= NS; s++) begin : g_en
    assign en[s] = !v[s] || en[s+1];
  end

  logic      op_q  [1:5];
  logic [15:0] idx_q [1:5];
  entry_t    ent_q [1:5];
  pix_side_t side_q [1:NS];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) begin
        v[1] <= in_valid;
      end
      for (int s = 2; s <= NS; s++) begin
        if (en[s]) begin
          v[s] <= (s == 6) ? (v[5] && op_q[5] == OP_PIXEL) : v[s-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      op_q[1]   <= opcode;
      idx_q[1]  <= entry_index;
      ent_q[1]  <= {entry_blue, entry_green, entry_red};
      side_q[1] <= '{px: {pixel_blue, pixel_green, pixel_red},
                     alpha: pixel_alpha, frame_end: frame_end};
    end
    for (int s = 2; s <= 5; s++) begin
      if (en[s]) begin
        op_q[s]  <= op_q[s-1];
        idx_q[s] <= idx_q[s-1];
        ent_q[s] <= ent_q[s-1];
      end
    end
    for (int s = 2; s <= NS; s++) begin
      if (en[s]) begin
        side_q[s] <= side_q[s-1];
      end
    end
  end

  logic [2:0][PROD_W-1:0]    prod_q;
  logic [2:0][SIDE_W-1:0]    lo_d;
  logic [2:0][7:0]           rem_d;
  logic [2:0][SIDE_W-1:0]    lo_q3;
  logic [2:0][7:0]           rem_q3;
  logic [2:0][FRAC_BITS-1:0] frac_q4;
  logic [SIDE_W-1:0]         lo_r_q4;
  logic [ADDR_W-1:0]         bnn_q4;
  logic [ADDR_W-1:0]         gn_q4;
  logic [ADDR_W-1:0]         base_q5;
  logic [2:0][FRAC_BITS-1:0] frac_q5;
  logic [2:0][FRAC_BITS-1:0] frac_q6;
  logic [FRAC_BITS-1:0]      frac_g_q7;
  logic [FRAC_BITS-1:0]      frac_b_q7;
  logic [FRAC_BITS-1:0]      frac_b_q8;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      lo_d[c]  = SIDE_W'(((QW'(prod_q[c]) + QW'(1)) * QW'(257)) >> 16);
      rem_d[c] = 8'(prod_q[c] - PROD_W'(lo_d[c]) * PROD_W'(255));
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int c = 0; c < 3; c++) begin
        prod_q[c] <= PROD_W'(side_q[1].px[c]) * PROD_W'(side_nm1);
      end
    end
    if (en[3]) begin
      lo_q3  <= lo_d;
      rem_q3 <= rem_d;
    end
    if (en[4]) begin
      for (int c = 0; c < 3; c++) begin
        frac_q4[c] <= FRAC_BITS'((FP_W'(rem_q3[c]) * FP_W'(FRAC_RECIP)) >> 16);
      end
      lo_r_q4 <= lo_q3[0];
      bnn_q4  <= ADDR_W'(lo_q3[2]) * ADDR_W'(side_nn);
      gn_q4   <= ADDR_W'(lo_q3[1]) * ADDR_W'(side_n);
    end
    if (en[5]) begin
      base_q5 <= bnn_q4 + gn_q4 + ADDR_W'(lo_r_q4);
      frac_q5 <= frac_q4;
    end
    if (en[6]) begin
      frac_q6 <= frac_q5;
    end
    if (en[7]) begin
      frac_g_q7 <= frac_q6[1];
      frac_b_q7 <= frac_q6[2];
    end
    if (en[8]) begin
      frac_b_q8 <= frac_b_q7;
    end
  end

  logic [3:0][ADDR_W-1:0] rd_addr;
  logic                   wr_en;
  entry_t [3:0]           rd_lo;
  entry_t [3:0]           rd_hi;

  assign rd_addr[0] = base_q5;
  assign rd_addr[1] = base_q5 + ADDR_W'(side_n);
  assign rd_addr[2] = base_q5 + ADDR_W'(side_nn);
  assign rd_addr[3] = base_q5 + ADDR_W'(side_nn) + ADDR_W'(side_n);

  assign wr_en = v[5] && (op_q[5] == OP_WRITE) && en[6] && (32'(idx_q[5]) < DEPTH);

  l3d_table #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (MEM_AW'(idx_q[5])),
    .wr_data (ent_q[5]),
    .rd_en   (en[6]),
    .rd_addr (rd_addr),
    .rd_lo   (rd_lo),
    .rd_hi   (rd_hi)
  );

  logic [2:0][3:0][15:0] l1_d;
  logic [2:0][3:0][15:0] l1_q;
  logic [2:0][1:0][15:0] l2_d;
  logic [2:0][1:0][15:0] l2_q;
  logic [2:0][15:0]      m_d;
  logic [2:0][15:0]      m_q;
  logic [2:0][15:0]      o16_d;
  logic [2:0][15:0]      o16_q;
  logic [2:0][7:0]       byte_d;
  logic [2:0][7:0]       out_q;

  for (genvar c = 0; c < 3; c++) begin : g_ch
    for (genvar j = 0; j < 4; j++) begin : g_l1
      l3d_lerp #(.FRAC_BITS(FRAC_BITS)) u_l1 (
        .a (rd_lo[j][c]),
        .b (rd_hi[j][c]),
        .f (frac_q6[0]),
        .y (l1_d[c][j])
      );
    end
    for (genvar j = 0; j < 2; j++) begin : g_l2
      l3d_lerp #(.FRAC_BITS(FRAC_BITS)) u_l2 (
        .a (l1_q[c][2*j]),
        .b (l1_q[c][2*j+1]),
        .f (frac_g_q7),
        .y (l2_d[c][j])
      );
    end
    l3d_lerp #(.FRAC_BITS(FRAC_BITS)) u_l3 (
      .a (l2_q[c][0]),
      .b (l2_q[c][1]),
      .f (frac_b_q8),
      .y (m_d[c])
    );
  end

  always_comb begin
    logic [24:0] y;
    logic [24:0] q;
    for (int c = 0; c < 3; c++) begin
      o16_d[c] = 16'((26'({side_q[9].px[c], side_q[9].px[c]}) * 26'(k_inv)
                      + 26'(m_q[c]) * 26'(k_eff) + 26'd128) >> 8);
      y = 25'(o16_q[c]) * 25'd255 + 25'd32767;
      q = (y + (y >> 16) + 25'd1) >> 16;
      byte_d[c] = bypass ? side_q[10].px[c] : 8'(q);
    end
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      l1_q <= l1_d;
    end
    if (en[8]) begin
      l2_q <= l2_d;
    end
    if (en[9]) begin
      m_q <= m_d;
    end
    if (en[10]) begin
      o16_q <= o16_d;
    end
    if (en[11]) begin
      out_q <= byte_d;
    end
  end

  assign in_ready      = en[1];
  assign out_valid     = v[NS];
  assign mapped_red    = out_q[0];
  assign mapped_green  = out_q[1];
  assign mapped_blue   = out_q[2];
  assign mapped_alpha  = side_q[NS].alpha;
  assign frame_end_out = side_q[NS].frame_end;

endmodule

// ===== rtl/core/l3d_lerp.sv =====
module l3d_lerp #(
  parameter int FRAC_BITS = 16
) (
  input  logic [15:0]          a,
  input  logic [15:0]          b,
  input  logic [FRAC_BITS-1:0] f,
  output logic [15:0]          y
);

  localparam int SW = FRAC_BITS + 18;
  localparam logic [FRAC_BITS:0] ONE  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [FRAC_BITS:0] HALF = ONE >> 1;

  logic [SW-1:0] sum;

  assign sum = SW'(a) * SW'(ONE - {1'b0, f}) + SW'(b) * SW'(f) + SW'(HALF);

  // With a zero fraction the far point carries no weight, so it is not looked at.
  assign y = (f == '0) ? a : 16'(sum >> FRAC_BITS);

endmodule

// ===== rtl/core/l3d_table.sv =====
module l3d_table
  import l3d_pkg::*;
#(
  parameter int DEPTH  = 35937,
  parameter int ADDR_W = 17
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  entry_t                   wr_data,
  input  logic                     rd_en,
  input  logic [3:0][ADDR_W-1:0]   rd_addr,
  output entry_t [3:0]             rd_lo,
  output entry_t [3:0]             rd_hi
);

  localparam int MEM_AW = $clog2(DEPTH);

  for (genvar c = 0; c < 4; c++) begin : g_copy
    entry_t            mem [DEPTH];
    entry_t            lo_q;
    entry_t            hi_q;
    logic [ADDR_W-1:0] next_addr;
    logic [MEM_AW-1:0] lo_addr;
    logic [MEM_AW-1:0] hi_addr;

    assign next_addr = rd_addr[c] + ADDR_W'(1);
    assign lo_addr = (rd_addr[c] >= ADDR_W'(DEPTH)) ? MEM_AW'(DEPTH - 1) : MEM_AW'(rd_addr[c]);
    assign hi_addr = (next_addr >= ADDR_W'(DEPTH)) ? MEM_AW'(DEPTH - 1) : MEM_AW'(next_addr);

    always_ff @(posedge clk) begin
      if (wr_en) begin
        mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
        lo_q <= mem[lo_addr];
        hi_q <= mem[hi_addr];
      end
    end

    assign rd_lo[c] = lo_q;
    assign rd_hi[c] = hi_q;
  end

endmodule

// ===== sim/lut3d_trilinear_pixel_map_core_tb.sv =====
module lut3d_trilinear_pixel_map_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import l3d_pkg::*;

  localparam int TABLE_DEPTH = 35937;
  localparam int SIDE_MAX = 33;
  localparam int DRAIN_CYCLES = 16;
  localparam logic [1:0] REG_SPARE_A = 2'd2;
  localparam logic [1:0] REG_SPARE_B = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [8:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic opcode = OP_WRITE;
  logic [15:0] entry_index = '0, entry_red = '0, entry_green = '0, entry_blue = '0;
  logic [7:0] pixel_red = '0, pixel_green = '0, pixel_blue = '0, pixel_alpha = '0;
  logic frame_end = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] mapped_red, mapped_green, mapped_blue, mapped_alpha;
  logic frame_end_out;

  typedef struct {
    logic [7:0] red, green, blue, alpha;
    logic       last;
  } graded_pixel_t;

  graded_pixel_t graded_q[$];
  entry_t lut_copy[TABLE_DEPTH];
  bit loaded[TABLE_DEPTH];
  int side_reg = 0;
  int blend_reg = 256;
  int send_idle = 0;
  int recv_idle = 0;
  int errors = 0;
  int items_sent = 0;

  lut3d_trilinear_pixel_map_core u_dut (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #1ms;
    $display("DONE: errors detected");
    $finish;
  end

  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= recv_idle);
  end

  function automatic void split_axis(input int p, input int n, output int lo,
                                     output int hi, output longint fr);
    int prod;
    prod = p * (n - 1);
    lo = prod / 255;
    hi = (lo + 1 < n - 1) ? lo + 1 : n - 1;
    fr = (longint'(prod - lo * 255) << 16) / 255;
  endfunction

  function automatic longint lerp16(input longint a, input longint b, input longint f);
    return (a * (65536 - f) + b * f + 32768) >>> 16;
  endfunction

  function automatic int eff_side();
    return (side_reg > SIDE_MAX) ? SIDE_MAX : side_reg;
  endfunction

  function automatic graded_pixel_t grade_pixel(input logic [2:0][7:0] px,
                                                input logic [7:0] alpha,
                                                input logic last);
    graded_pixel_t res;
    int n, k, lo[3], hi[3];
    longint fr[3], c[8], m, o16, byt;
    logic [7:0] outb[3];
    res.alpha = alpha;
    res.last = last;
    n = eff_side();
    k = (blend_reg > 256) ? 256 : blend_reg;
    for (int ch = 0; ch < 3; ch++) begin
      outb[ch] = px[ch];
      if (n != 0) split_axis(px[ch], n, lo[ch], hi[ch], fr[ch]);
    end
    if (n != 0) begin
      for (int ch = 0; ch < 3; ch++) begin
        for (int j = 0; j < 8; j++) begin
          c[j] = lut_copy[(j[2] ? hi[2] : lo[2]) * n * n + (j[1] ? hi[1] : lo[1]) * n
                          + (j[0] ? hi[0] : lo[0])][ch];
        end
        m = lerp16(lerp16(lerp16(c[0], c[1], fr[0]), lerp16(c[2], c[3], fr[0]), fr[1]),
                   lerp16(lerp16(c[4], c[5], fr[0]), lerp16(c[6], c[7], fr[0]), fr[1]),
                   fr[2]);
        o16 = (longint'(px[ch]) * 257 * (256 - k) + m * k + 128) >>> 8;
        byt = (o16 * 255 + 32767) / 65535;
        outb[ch] = (byt > 255) ? 8'd255 : byt[7:0];
      end
    end
    res.red = outb[0];
    res.green = outb[1];
    res.blue = outb[2];
    return res;
  endfunction

  function automatic logic [15:0] rand_chan();
    if ($urandom_range(3) == 0) return $urandom_range(1) ? 16'hFFFF : 16'h0000;
    return 16'($urandom_range(65535));
  endfunction

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_item(input logic op, input logic [15:0] idx, input logic [15:0] er,
                           input logic [15:0] eg, input logic [15:0] eb,
                           input logic [7:0] pr, input logic [7:0] pg, input logic [7:0] pb,
                           input logic [7:0] pa, input logic fe);
    entry_t e;
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    opcode = op;
    entry_index = idx;
    entry_red = er;
    entry_green = eg;
    entry_blue = eb;
    pixel_red = pr;
    pixel_green = pg;
    pixel_blue = pb;
    pixel_alpha = pa;
    frame_end = fe;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (op == OP_WRITE) begin
      if (idx < TABLE_DEPTH) begin
        e[0] = er;
        e[1] = eg;
        e[2] = eb;
        lut_copy[idx] = e;
        loaded[idx] = 1'b1;
      end
    end else begin
      graded_q.insert(graded_q.size(), grade_pixel({pb, pg, pr}, pa, fe));
    end
  endtask

  task automatic write_entry(input int idx, input logic [15:0] er, input logic [15:0] eg,
                             input logic [15:0] eb);
    send_item(OP_WRITE, 16'(idx), er, eg, eb, rand_byte(), rand_byte(), rand_byte(),
              rand_byte(), 1'($urandom_range(1)));
  endtask

  task automatic send_pixel(input logic [7:0] pr, input logic [7:0] pg, input logic [7:0] pb,
                            input logic [7:0] pa, input logic fe);
    int n, idx, lo[3], hi[3];
    longint fr;
    n = eff_side();
    if (n != 0) begin
      split_axis(pr, n, lo[0], hi[0], fr);
      split_axis(pg, n, lo[1], hi[1], fr);
      split_axis(pb, n, lo[2], hi[2], fr);
      for (int j = 0; j < 8; j++) begin
        idx = (j[2] ? hi[2] : lo[2]) * n * n + (j[1] ? hi[1] : lo[1]) * n
              + (j[0] ? hi[0] : lo[0]);
        if (!loaded[idx]) write_entry(idx, rand_chan(), rand_chan(), rand_chan());
      end
    end
    send_item(OP_PIXEL, 16'($urandom_range(65535)), rand_chan(), rand_chan(), rand_chan(),
              pr, pg, pb, pa, fe);
  endtask

  task automatic configure(input logic [1:0] idx, input logic [8:0] value);
    @(negedge clk);
    in_valid = 1'b0;
    while (graded_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_write = 1'b0;
    if (idx == REG_LUT_SIDE) side_reg = value[5:0];
    else if (idx == REG_BLEND) blend_reg = value;
  endtask

  task automatic note_error(input string what, input int exp_v, input int act_v);
    errors++;
    if (errors <= 10) $display("mismatch on %s: expected %0d, got %0d", what, exp_v, act_v);
  endtask

  always @(posedge clk) begin
    graded_pixel_t want;
    if (!rst && out_valid && out_ready) begin
      if (graded_q.size() == 0) begin
        note_error("unexpected transaction", 0, 1);
      end else begin
        want = graded_q.pop_front();
        if (mapped_red !== want.red) note_error("mapped_red", want.red, mapped_red);
        if (mapped_green !== want.green) note_error("mapped_green", want.green, mapped_green);
        if (mapped_blue !== want.blue) note_error("mapped_blue", want.blue, mapped_blue);
        if (mapped_alpha !== want.alpha) note_error("mapped_alpha", want.alpha, mapped_alpha);
        if (frame_end_out !== want.last) note_error("frame_end_out", want.last, frame_end_out);
      end
    end
  end

  task automatic test_bypass();
    configure(REG_LUT_SIDE, 9'd0);
    configure(REG_BLEND, BLEND_FULL);
    send_pixel(8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
    send_pixel(8'd170, 8'd85, 8'd1, 8'd128, 1'b0);
  endtask

  task automatic test_small_table();
    configure(REG_LUT_SIDE, 9'd2);
    for (int i = 0; i < 8; i++) begin
      write_entry(i, i[0] ? 16'hFFFF : 16'h0000, i[1] ? 16'hFFFF : 16'h0000,
                  i[2] ? 16'hFFFF : 16'h0000);
    end
    send_pixel(8'd0, 8'd0, 8'd0, 8'd7, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
    send_pixel(8'd128, 8'd1, 8'd254, 8'd0, 1'b0);
    configure(REG_BLEND, 9'd0);
    send_pixel(8'd200, 8'd30, 8'd99, 8'd1, 1'b0);
    configure(REG_BLEND, 9'd128);
    send_pixel(8'd200, 8'd30, 8'd99, 8'd2, 1'b1);
    configure(REG_SPARE_A, 9'd5);
    configure(REG_SPARE_B, 9'd511);
    send_pixel(8'd64, 8'd192, 8'd17, 8'd3, 1'b0);
  endtask

  task automatic test_limits();
    write_entry(TABLE_DEPTH, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    write_entry(65535, 16'h1234, 16'h5678, 16'h9ABC);
    configure(REG_LUT_SIDE, 9'd63);
    configure(REG_BLEND, 9'd511);
    send_pixel(8'd0, 8'd0, 8'd0, 8'd4, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 8'd5, 1'b1);
    configure(REG_LUT_SIDE, 9'd1);
    send_pixel(8'd77, 8'd255, 8'd0, 8'd6, 1'b0);
  endtask

  task automatic test_random(input int s_idle, input int r_idle, input int target);
    int sides[8] = '{1, 2, 3, 5, 9, 17, 33, 0};
    int blends[5] = '{0, 1, 128, 256, 511};
    send_idle = s_idle;
    recv_idle = r_idle;
    while (items_sent < target) begin
      configure(REG_LUT_SIDE, 9'($urandom_range(9) < 8 ? sides[$urandom_range(7)]
                                                        : $urandom_range(63)));
      configure(REG_BLEND, 9'($urandom_range(2) == 0 ? $urandom_range(511)
                                                     : blends[$urandom_range(4)]));
      repeat (40) begin
        if ($urandom_range(99) < 85) begin
          send_pixel(rand_byte(), rand_byte(), rand_byte(), rand_byte(),
                     1'($urandom_range(1)));
        end else begin
          write_entry($urandom_range(65535), rand_chan(), rand_chan(), rand_chan());
        end
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_bypass();
    test_small_table();
    test_limits();
    test_random(25, 53, 370);
    test_random(53, 25, 740);
    test_random(0, 0, 1100);
    @(negedge clk);
    in_valid = 1'b0;
    while (graded_q.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
